>>> rtl/bmp_pkg.sv
// Package for the peak-hold bar meter: constants, register indexes,
// the per-bar state word and the sequencer states. No dependencies.
package bmp_pkg;

    // Default bar count and field widths
    localparam int BMP_NUM_BARS   = 128;
    localparam int BMP_IDX_W      = 7;
    localparam int BMP_LEVEL_W    = 18;
    localparam int BMP_HEIGHT_W   = 16;
    localparam int BMP_HOLD_W     = 8;
    localparam int BMP_FULL_W     = 8;
    localparam int BMP_CFG_IDX_W  = 2;
    localparam int BMP_CFG_DATA_W = 16;
    localparam int BMP_IN_DATA_W  = 32;
    localparam int BMP_OUT_DATA_W = 40;

    // Clamped level: 0..65536, full scale is one
    localparam int BMP_LVL_CLAMP_W = 17;
    localparam logic [BMP_LVL_CLAMP_W-1:0] BMP_LVL_FULL = 17'h10000;

    // Register reset values
    localparam logic [BMP_FULL_W-1:0]   BMP_RST_FULL_HEIGHT = 8'd16;
    localparam logic [BMP_HEIGHT_W-1:0] BMP_RST_FALL_STEP   = 16'd256;
    localparam logic [BMP_HOLD_W-1:0]   BMP_RST_HOLD_FRAMES = 8'd8;
    localparam logic [BMP_HEIGHT_W-1:0] BMP_RST_GRAVITY     = 16'd32;

    // Register indexes on the configuration port
    typedef enum logic [BMP_CFG_IDX_W-1:0] {
        CFG_FULL_HEIGHT = 2'd0,
        CFG_FALL_STEP   = 2'd1,
        CFG_HOLD_FRAMES = 2'd2,
        CFG_GRAVITY     = 2'd3
    } bmp_cfg_idx_t;

    // State kept for one bar, one memory word
    typedef struct packed {
        logic [BMP_HOLD_W-1:0]   hold;
        logic [BMP_HEIGHT_W-1:0] vel;
        logic [BMP_HEIGHT_W-1:0] peak;
        logic [BMP_HEIGHT_W-1:0] bar;
    } bmp_entry_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CALC
    } bmp_state_t;

endpackage

>>> rtl/bmp_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
module bmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/bar_meter_peak_hold_gravity_unit.sv
// Top level of the peak-hold bar meter with gravity decay.
// Depends on bmp_pkg and bmp_ram (per-bar state memory).
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+---------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | s_tdata: bar_index, level
//  m_*      | out | m_tvalid/m_tready  | m_tdata: bar_number, bar_height, peak
//  cfg_*    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// From accept to result each item runs in order: the memory read is
// issued at the accept edge, then bar update, then peak update with
// write-back. The next item is accepted in the write-back cycle, so
// the block can take a new item before the last one is written back;
// the rate is set by the read-modify-write loop on the single state memory;
// a repeat of the same bar is served by forwarding the written word.
// After reset a clearing pass writes NUM_BARS zero words, one per cycle,
// before s_tready rises. A stalled m_tready holds the result register and
// the write-back cycle; configuration writes are always taken.
module bar_meter_peak_hold_gravity_unit #(
    parameter int NUM_BARS = bmp_pkg::BMP_NUM_BARS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // bar_index [6:0], level [24:7], zero fill
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bmp_pkg::BMP_IN_DATA_W-1:0]   s_tdata,
    // bar_number [6:0], bar_height [22:7], peak_height [38:23], zero fill
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bmp_pkg::BMP_OUT_DATA_W-1:0]  m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bmp_pkg::BMP_CFG_IDX_W-1:0]   cfg_index,
    input  logic [bmp_pkg::BMP_CFG_DATA_W-1:0]  cfg_data
);

    import bmp_pkg::*;

    localparam int AW = (NUM_BARS > 1) ? $clog2(NUM_BARS) : 1;
    localparam int PROD_W = BMP_LVL_CLAMP_W + BMP_FULL_W;

    // Configuration registers
    logic [BMP_FULL_W-1:0]   full_height_reg;
    logic [BMP_HEIGHT_W-1:0] fall_step_reg;
    logic [BMP_HOLD_W-1:0]   hold_frames_reg;
    logic [BMP_HEIGHT_W-1:0] gravity_reg;

    // Control
    bmp_state_t state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg;
    logic          out_valid_reg;
    logic          fwd_reg;

    // Stage 1: accepted item
    logic [BMP_IDX_W-1:0]    s1_idx_reg;
    logic                    s1_in_range_reg;
    logic [BMP_HEIGHT_W-1:0] s1_target_reg;
    bmp_entry_t              fwd_data_reg;

    // Stage 2: bar updated
    logic [BMP_IDX_W-1:0]    s2_idx_reg;
    logic                    s2_in_range_reg;
    logic [BMP_HEIGHT_W-1:0] s2_bar_reg;
    logic [BMP_HEIGHT_W-1:0] s2_peak_reg;
    logic [BMP_HEIGHT_W-1:0] s2_vel_reg;
    logic [BMP_HEIGHT_W-1:0] s2_vsat_reg;
    logic [BMP_HOLD_W-1:0]   s2_hold_reg;

    logic [BMP_OUT_DATA_W-1:0] out_data_reg;

    // Combinational signals
    logic                       accept;
    logic                       out_free;
    logic                       calc_go;
    logic [BMP_IDX_W-1:0]       in_idx;
    logic signed [BMP_LEVEL_W-1:0] in_level;
    logic [BMP_LVL_CLAMP_W-1:0] lvl_clamp;
    logic [PROD_W-1:0]          product;
    logic                       in_range;
    bmp_entry_t                 rd_entry;
    bmp_entry_t                 ram_rdata;
    logic [BMP_HEIGHT_W:0]      fallen;
    logic [BMP_HEIGHT_W-1:0]    bar_new;
    logic [BMP_HEIGHT_W:0]      vel_sum;
    logic [BMP_HEIGHT_W-1:0]    vsat;
    bmp_entry_t                 wr_entry;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    bmp_entry_t                 ram_wdata;
    logic [BMP_OUT_DATA_W-1:0]  out_word;

    assign in_idx   = s_tdata[BMP_IDX_W-1:0];
    assign in_level = s_tdata[BMP_IDX_W +: BMP_LEVEL_W];

    assign out_free  = !out_valid_reg || m_tready;
    assign calc_go   = (state_reg == ST_CALC) && out_free;
    assign s_tready  = (state_reg == ST_IDLE) || calc_go;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Level clamp and target scaling
    always_comb
    begin
        if (in_level[BMP_LEVEL_W-1])
        begin
            lvl_clamp = '0;
        end
        else if (in_level[BMP_LEVEL_W-2:0] > BMP_LVL_FULL)
        begin
            lvl_clamp = BMP_LVL_FULL;
        end
        else
        begin
            lvl_clamp = in_level[BMP_LVL_CLAMP_W-1:0];
        end
        product = PROD_W'(lvl_clamp) * PROD_W'(full_height_reg);
    end

    assign in_range = (32'(in_idx) < NUM_BARS);

    // State memory
    bmp_ram #(
        .WIDTH ($bits(bmp_entry_t)),
        .DEPTH (NUM_BARS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (AW'(in_idx)),
        .rdata (ram_rdata)
    );

    assign rd_entry = fwd_reg ? fwd_data_reg : ram_rdata;

    // Bar update and next velocity
    always_comb
    begin
        fallen = {1'b0, rd_entry.bar} - {1'b0, fall_step_reg};
        if (s1_target_reg >= rd_entry.bar)
        begin
            bar_new = s1_target_reg;
        end
        else if (!fallen[BMP_HEIGHT_W] && (fallen[BMP_HEIGHT_W-1:0] > s1_target_reg))
        begin
            bar_new = fallen[BMP_HEIGHT_W-1:0];
        end
        else
        begin
            bar_new = s1_target_reg;
        end
        vel_sum = {1'b0, rd_entry.vel} + {1'b0, gravity_reg};
        vsat    = vel_sum[BMP_HEIGHT_W] ? '1 : vel_sum[BMP_HEIGHT_W-1:0];
    end

    // Peak update
    always_comb
    begin
        wr_entry.bar = s2_bar_reg;
        if (s2_bar_reg >= s2_peak_reg)
        begin
            wr_entry.peak = s2_bar_reg;
            wr_entry.vel  = '0;
            wr_entry.hold = hold_frames_reg;
        end
        else if (s2_hold_reg != '0)
        begin
            wr_entry.peak = s2_peak_reg;
            wr_entry.vel  = s2_vel_reg;
            wr_entry.hold = s2_hold_reg - BMP_HOLD_W'(1);
        end
        else
        begin
            wr_entry.vel  = s2_vsat_reg;
            wr_entry.hold = s2_hold_reg;
            wr_entry.peak = (s2_peak_reg >= s2_vsat_reg) ? (s2_peak_reg - s2_vsat_reg) : '0;
        end
    end

    // Write port: clearing pass or write-back
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = calc_go && s2_in_range_reg;
            ram_waddr = AW'(s2_idx_reg);
            ram_wdata = wr_entry;
        end
    end

    // Result word, zero heights for an index beyond the bar count
    always_comb
    begin
        out_word = '0;
        out_word[BMP_IDX_W-1:0] = s2_idx_reg;
        if (s2_in_range_reg)
        begin
            out_word[BMP_IDX_W +: BMP_HEIGHT_W]                = wr_entry.bar;
            out_word[BMP_IDX_W + BMP_HEIGHT_W +: BMP_HEIGHT_W] = wr_entry.peak;
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == AW'(NUM_BARS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                if (calc_go)
                begin
                    state_next = accept ? ST_READ : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            fwd_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (calc_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                fwd_reg <= calc_go && (in_idx == s2_idx_reg);
            end
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_height_reg <= BMP_RST_FULL_HEIGHT;
            fall_step_reg   <= BMP_RST_FALL_STEP;
            hold_frames_reg <= BMP_RST_HOLD_FRAMES;
            gravity_reg     <= BMP_RST_GRAVITY;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (bmp_cfg_idx_t'(cfg_index))
                CFG_FULL_HEIGHT: full_height_reg <= cfg_data[BMP_FULL_W-1:0];
                CFG_FALL_STEP:   fall_step_reg   <= cfg_data;
                CFG_HOLD_FRAMES: hold_frames_reg <= cfg_data[BMP_HOLD_W-1:0];
                CFG_GRAVITY:     gravity_reg     <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_idx_reg      <= in_idx;
            s1_in_range_reg <= in_range;
            s1_target_reg   <= product[BMP_FULL_W +: BMP_HEIGHT_W];
            fwd_data_reg    <= wr_entry;
        end
        if (state_reg == ST_READ)
        begin
            s2_idx_reg      <= s1_idx_reg;
            s2_in_range_reg <= s1_in_range_reg;
            s2_bar_reg      <= bar_new;
            s2_peak_reg     <= rd_entry.peak;
            s2_vel_reg      <= rd_entry.vel;
            s2_vsat_reg     <= vsat;
            s2_hold_reg     <= rd_entry.hold;
        end
        if (calc_go)
        begin
            out_data_reg <= out_word;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
